FILE: rtl/core/nls_pkg.sv
// Shared types and constants for the nearest light selector.
// No dependencies.
`timescale 1ns / 1ps
package nls_pkg;
    localparam int MAX_SLOTS   = 8;
    localparam int SLOT_BITS   = $clog2(MAX_SLOTS);
    localparam int CNT_BITS    = $clog2(MAX_SLOTS + 1);
    localparam int INDEX_BITS  = 12;
    localparam int CFG_BITS    = 12;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] REQ_START    = 2'd0;
    localparam logic [1:0] REQ_LIGHT    = 2'd1;
    localparam logic [1:0] REQ_FINISH   = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic [1:0] KIND_DIR    = 2'd0;
    localparam logic [1:0] KIND_RADIAL = 2'd1;
    localparam logic [1:0] KIND_SPOT   = 2'd2;

    localparam logic CFG_NUM_DIR    = 1'b0;
    localparam logic CFG_NUM_RADIAL = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0] sphere_radius;
        logic [11:0] light_index;
    } req_t;

    typedef struct packed {
        logic [11:0] chosen_index;
        logic [1:0]  chosen_kind;
        logic        none_chosen;
        logic [3:0]  count_dir;
        logic [3:0]  count_radial;
        logic [3:0]  count_spot;
        logic        last;
    } rsp_t;

    // Classified command passed from front to back.
    typedef struct packed {
        logic [1:0]  op;
        logic        hit;       // candidate touches the sphere
        logic [63:0] sq_dist;   // squared distance (low 64 bits)
        logic [11:0] idx;
    } cmd_t;
endpackage

FILE: rtl/core/nls_stream_if.sv
// Valid/ready channel carrying one payload type.
// No dependencies.
`timescale 1ns / 1ps
interface nls_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/nls_front.sv
// Front end: takes requests, computes squared distance and touch test for
// lights (one multiply a cycle), and queues a classified command per start,
// light or finish request. Depends on nls_pkg.
`timescale 1ns / 1ps
module nls_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nls_pkg::req_t in_data,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output nls_pkg::cmd_t cmd_data
);
    import nls_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MX   = 3'd1;
    localparam logic [2:0] ST_MY   = 3'd2;
    localparam logic [2:0] ST_MZ   = 3'd3;
    localparam logic [2:0] ST_MR   = 3'd4;
    localparam logic [2:0] ST_CMP  = 3'd5;
    localparam logic [2:0] ST_PUSH = 3'd6;

    logic [2:0]  state_reg, state_next;
    req_t        req_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0] cr_reg;
    logic [32:0] dx_reg, dy_reg, dz_reg;   // magnitudes, below 2^32
    logic [65:0] acc_reg;
    logic [63:0] lim_reg;
    cmd_t        q_mem [QUEUE_DEPTH];
    logic [$clog2(QUEUE_DEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] cnt_reg;

    logic [32:0] mag_sel;
    logic [65:0] sq;
    logic [31:0] rsum;
    logic        push, pop;
    cmd_t        cmd_new;

    function automatic logic [32:0] absdiff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32] ? 33'(-d) : d;
    endfunction

    always_comb
    begin
        rsum = 32'(cr_reg) + 32'(req_reg.sphere_radius);
        case (state_reg)
            ST_MX:   mag_sel = dx_reg;
            ST_MY:   mag_sel = dy_reg;
            ST_MR:   mag_sel = 33'(rsum);
            default: mag_sel = dz_reg;
        endcase
        sq = 66'(mag_sel) * 66'(mag_sel);
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign push      = (state_reg == ST_PUSH) && (cnt_reg != QUEUE_DEPTH[$bits(cnt_reg)-1:0]);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd_data  = q_mem[rp_reg];

    always_comb
    begin
        cmd_new.op      = req_reg.req_type;
        cmd_new.hit     = (acc_reg[65:64] == 2'b00) && (acc_reg[63:0] <= lim_reg);
        cmd_new.sq_dist = acc_reg[63:0];
        cmd_new.idx     = req_reg.light_index;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    if (in_data.req_type == REQ_LIGHT)
                        state_next = ST_MX;
                    else if (in_data.req_type == REQ_START || in_data.req_type == REQ_FINISH)
                        state_next = ST_PUSH;
                end
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_MZ;
            ST_MZ:   state_next = ST_MR;
            ST_MR:   state_next = ST_CMP;
            ST_CMP:  state_next = ST_PUSH;
            ST_PUSH: if (push) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
            cr_reg <= '0;
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && in_ready && in_data.req_type == REQ_START)
            begin
                cx_reg <= in_data.pos_x;
                cy_reg <= in_data.pos_y;
                cz_reg <= in_data.pos_z;
                cr_reg <= in_data.sphere_radius;
            end
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
            dx_reg  <= absdiff(in_data.pos_x, cx_reg);
            dy_reg  <= absdiff(in_data.pos_y, cy_reg);
            dz_reg  <= absdiff(in_data.pos_z, cz_reg);
            acc_reg <= '0;
        end
        case (state_reg)
            ST_MX, ST_MY, ST_MZ: acc_reg <= acc_reg + sq;
            // radius sum is below 2^32, so its square fits 64 bits
            ST_MR: lim_reg <= sq[63:0];
            default: ;
        endcase
        if (push)
            q_mem[wp_reg] <= cmd_new;
    end
endmodule

FILE: rtl/core/nls_back.sv
// Back end: holds the slot table, applies start/candidate commands, rescans
// for the furthest slot one slot a cycle, and streams finish results.
// Depends on nls_pkg.
`timescale 1ns / 1ps
module nls_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  nls_pkg::cmd_t cmd_data,
    input  logic [11:0]   num_dir_lights,
    input  logic [11:0]   num_radial_lights,
    output logic          out_valid,
    input  logic          out_ready,
    output nls_pkg::rsp_t out_data
);
    import nls_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_CNT  = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;

    logic [2:0]  state_reg;
    logic [INDEX_BITS-1:0] light_reg [MAX_SLOTS];
    logic [63:0] dist_reg [MAX_SLOTS];
    logic [CNT_BITS-1:0] filled_reg, dir_reg;
    logic [SLOT_BITS-1:0] far_slot_reg;
    logic [63:0] far_dist_reg;
    logic        far_known_reg;
    logic [CNT_BITS-1:0] ptr_reg;      // scan/emit slot pointer
    logic [1:0]  pass_reg;             // emit group
    logic [CNT_BITS-1:0] cr_reg, cs_reg, k_reg;
    logic [12:0] spot_start_reg;
    logic        out_valid_reg;
    rsp_t        out_reg;

    logic [CNT_BITS-1:0] total;
    logic [SLOT_BITS-1:0] ps;
    logic        is_spot, in_point;
    logic        take;
    logic        out_set;

    assign ps       = ptr_reg[SLOT_BITS-1:0];
    assign is_spot  = {1'b0, light_reg[ps]} >= spot_start_reg;
    assign in_point = ptr_reg >= dir_reg && ptr_reg < filled_reg;
    assign total    = dir_reg + cr_reg + cs_reg;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_set  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready) &&
                      ((total == '0) || take);

    always_comb
    begin
        case (pass_reg)
            2'd0:    take = ptr_reg < dir_reg;
            2'd1:    take = in_point && !is_spot;
            default: take = in_point && is_spot;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            filled_reg <= '0;
            dir_reg <= '0;
            far_slot_reg <= '0;
            far_dist_reg <= '0;
            far_known_reg <= 1'b0;
            ptr_reg <= '0;
            pass_reg <= '0;
            cr_reg <= '0;
            cs_reg <= '0;
            k_reg <= '0;
            spot_start_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_set || (out_valid_reg && !out_ready);
            case (state_reg)
                ST_IDLE:
                    if (cmd_valid)
                    begin
                        case (cmd_data.op)
                            REQ_START:
                            begin
                                filled_reg <= (num_dir_lights > 12'(MAX_SLOTS)) ?
                                    CNT_BITS'(MAX_SLOTS) : num_dir_lights[CNT_BITS-1:0];
                                dir_reg <= (num_dir_lights > 12'(MAX_SLOTS)) ?
                                    CNT_BITS'(MAX_SLOTS) : num_dir_lights[CNT_BITS-1:0];
                                far_slot_reg <= '0;
                                far_dist_reg <= '0;
                                far_known_reg <= 1'b0;
                            end
                            REQ_LIGHT:
                                if (cmd_data.hit)
                                begin
                                    if (filled_reg < CNT_BITS'(MAX_SLOTS))
                                    begin
                                        if (cmd_data.sq_dist > far_dist_reg)
                                        begin
                                            far_slot_reg <= filled_reg[SLOT_BITS-1:0];
                                            far_dist_reg <= cmd_data.sq_dist;
                                            far_known_reg <= 1'b1;
                                        end
                                        filled_reg <= filled_reg + 1'b1;
                                    end
                                    else if (far_known_reg && cmd_data.sq_dist < far_dist_reg)
                                    begin
                                        far_dist_reg <= cmd_data.sq_dist;
                                        ptr_reg <= dir_reg;
                                        state_reg <= ST_SCAN;
                                    end
                                end
                            REQ_FINISH:
                            begin
                                spot_start_reg <= 13'(num_dir_lights) + 13'(num_radial_lights);
                                ptr_reg <= dir_reg;
                                cr_reg <= '0;
                                cs_reg <= '0;
                                state_reg <= ST_CNT;
                            end
                            default: ;
                        endcase
                    end
                // Walk point slots; strictly greater keeps the current slot on a tie.
                ST_SCAN:
                    if (ptr_reg >= CNT_BITS'(MAX_SLOTS))
                        state_reg <= ST_IDLE;
                    else
                    begin
                        if (dist_reg[ps] > far_dist_reg)
                        begin
                            far_dist_reg <= dist_reg[ps];
                            far_slot_reg <= ps;
                        end
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                ST_CNT:
                    if (ptr_reg >= filled_reg || ptr_reg >= CNT_BITS'(MAX_SLOTS))
                    begin
                        ptr_reg <= '0;
                        pass_reg <= '0;
                        k_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        if (is_spot)
                            cs_reg <= cs_reg + 1'b1;
                        else
                            cr_reg <= cr_reg + 1'b1;
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                ST_EMIT:
                    if (!out_valid_reg || out_ready)
                    begin
                        if (total == '0)
                        begin
                            out_reg <= '{chosen_index: '0, chosen_kind: KIND_DIR,
                                         none_chosen: 1'b1, count_dir: '0,
                                         count_radial: '0, count_spot: '0, last: 1'b1};
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            if (take)
                            begin
                                out_reg <= '{chosen_index: 12'(light_reg[ps]),
                                             chosen_kind: pass_reg,
                                             none_chosen: 1'b0,
                                             count_dir: 4'(dir_reg),
                                             count_radial: 4'(cr_reg),
                                             count_spot: 4'(cs_reg),
                                             last: (k_reg + 1'b1) == total};
                                k_reg <= k_reg + 1'b1;
                                if ((k_reg + 1'b1) == total)
                                    state_reg <= ST_IDLE;
                            end
                            // advance pointer, wrap into the next group
                            if (ptr_reg == CNT_BITS'(MAX_SLOTS - 1))
                            begin
                                ptr_reg <= (pass_reg == 2'd0) ? dir_reg : dir_reg;
                                pass_reg <= pass_reg + 1'b1;
                            end
                            else
                                ptr_reg <= ptr_reg + 1'b1;
                        end
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Slot table writes.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
        begin
            if (cmd_data.op == REQ_START)
            begin
                for (int i = 0; i < MAX_SLOTS; i++)
                    if (12'(i) < num_dir_lights)
                    begin
                        light_reg[i] <= INDEX_BITS'(i);
                        dist_reg[i]  <= '0;
                    end
            end
            else if (cmd_data.op == REQ_LIGHT && cmd_data.hit)
            begin
                if (filled_reg < CNT_BITS'(MAX_SLOTS))
                begin
                    light_reg[filled_reg[SLOT_BITS-1:0]] <= cmd_data.idx;
                    dist_reg[filled_reg[SLOT_BITS-1:0]]  <= cmd_data.sq_dist;
                end
                else if (far_known_reg && cmd_data.sq_dist < far_dist_reg)
                begin
                    light_reg[far_slot_reg] <= cmd_data.idx;
                    dist_reg[far_slot_reg]  <= cmd_data.sq_dist;
                end
            end
        end
    end
endmodule

FILE: rtl/core/nearest_light_selector_unit.sv
// Top level of the nearest light selector: config registers, front, back.
// Depends on nls_pkg, nls_stream_if, nls_front, nls_back.
//
// channel   | direction | payload
// req       | in        | nls_pkg::req_t
// rsp       | out       | nls_pkg::rsp_t
// cfg       | in        | cfg_we, cfg_index, cfg_data
//
// A candidate runs three squares and a radius square on one front
// multiplier, then a compare; a replacement adds a point-slot rescan in
// the back. A finish counts point slots, then walks up to 24 slot
// positions, one a cycle unless rsp stalls, with at most one result each.
// Reset clears all control; slots are written before read. A two-entry
// queue decouples front and back; rsp stalls hold the back, then the front.
`timescale 1ns / 1ps
module nearest_light_selector_unit (
    input  logic        clk,
    input  logic        rst_n,
    nls_stream_if.sink   req,
    nls_stream_if.source rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);
    import nls_pkg::*;

    logic [11:0] num_dir_reg, num_radial_reg;
    logic        cmd_valid, cmd_ready;
    cmd_t        cmd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dir_reg <= '0;
            num_radial_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NUM_DIR)
                num_dir_reg <= cfg_data;
            else
                num_radial_reg <= cfg_data;
        end
    end

    nls_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
    );

    nls_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
        .num_dir_lights(num_dir_reg), .num_radial_lights(num_radial_reg),
        .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
    );

    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.none_chosen |-> rsp.data.last)
        else $error("empty result without last");
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.data.none_chosen |->
        (rsp.data.count_dir + rsp.data.count_radial + rsp.data.count_spot) <= 4'(MAX_SLOTS))
        else $error("selection count overflow");
    a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid)
        else $error("queued command dropped");
endmodule
